// File: src/bhq_pkg.sv
// Shared constants for the binary min-heap priority queue.
package bhq_pkg;

  localparam int DEF_DEPTH    = 16;
  localparam int DEF_KEY_BITS = 63;
  localparam int LABEL_BITS   = 8;
  localparam int STATUS_BITS  = 2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

endpackage

// File: src/bhq_mem.sv
// Heap entry store: one write port, two registered read ports.
module bhq_mem #(
  parameter int DEPTH  = bhq_pkg::DEF_DEPTH,
  parameter int ENT_W  = bhq_pkg::DEF_KEY_BITS + bhq_pkg::LABEL_BITS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ENT_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [ENT_W-1:0]  rd_data_a,
  output logic [ENT_W-1:0]  rd_data_b
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: src/bhq_ctrl.sv
// Heap sequencer: push sift-up, pop sift-down and result register.
module bhq_ctrl #(
  parameter int DEPTH    = bhq_pkg::DEF_DEPTH,
  parameter int KEY_BITS = bhq_pkg::DEF_KEY_BITS,
  parameter int CNT_W    = $clog2(DEPTH + 1),
  parameter int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int ENT_W    = KEY_BITS + bhq_pkg::LABEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_valid,
  output logic                               s_ready,
  input  logic                               s_mode,
  input  logic [KEY_BITS-1:0]                s_key,
  input  logic [bhq_pkg::LABEL_BITS-1:0]     s_label,
  input  logic [CNT_W-1:0]                   capacity,
  output logic                               m_valid,
  input  logic                               m_ready,
  output logic [bhq_pkg::LABEL_BITS-1:0]     m_label,
  output logic [bhq_pkg::STATUS_BITS-1:0]    m_status,
  output logic [CNT_W-1:0]                   m_occupancy,
  output logic                               mem_wr_en,
  output logic [ADDR_W-1:0]                  mem_wr_addr,
  output logic [ENT_W-1:0]                   mem_wr_data,
  output logic [ADDR_W-1:0]                  mem_rd_addr_a,
  output logic [ADDR_W-1:0]                  mem_rd_addr_b,
  input  logic [ENT_W-1:0]                   mem_rd_data_a,
  input  logic [ENT_W-1:0]                   mem_rd_data_b
);
  import bhq_pkg::*;

  localparam int CH_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH_CMP = 3'd1;
  localparam logic [2:0] S_POP_LOAD = 3'd2;
  localparam logic [2:0] S_POP_CMP  = 3'd3;
  localparam logic [2:0] S_PLACE    = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
    parent_of = (p - ADDR_W'(1)) >> 1;
  endfunction

  function automatic logic [CH_W-1:0] left_of(input logic [ADDR_W-1:0] p);
    left_of = (CH_W'(p) << 1) + CH_W'(1);
  endfunction

  logic [2:0]                state, state_next;
  logic [CNT_W-1:0]          fill_count, fill_count_next;
  logic [ADDR_W-1:0]         pos, pos_next;
  logic [KEY_BITS-1:0]       key_q, key_q_next;
  logic [LABEL_BITS-1:0]     lab_q, lab_q_next;
  logic [LABEL_BITS-1:0]     res_label, res_label_next;
  logic [STATUS_BITS-1:0]    res_status, res_status_next;

  logic [CNT_W-1:0]          eff_cap;
  logic [CNT_W-1:0]          fill_dec;
  logic [ADDR_W-1:0]         fill_idx;
  logic [ADDR_W-1:0]         fill_dec_idx;
  logic [ADDR_W-1:0]         up;
  logic [CH_W-1:0]           child_l, child_r;
  logic                      right_ok, pick_right;
  logic [ENT_W-1:0]          ch_ent;
  logic [ADDR_W-1:0]         ch_idx;
  logic [CH_W-1:0]           gchild_l;
  logic                      out_free;

  assign eff_cap      = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
  assign fill_dec     = fill_count - CNT_W'(1);
  assign fill_idx     = fill_count[ADDR_W-1:0];
  assign fill_dec_idx = fill_dec[ADDR_W-1:0];
  assign up           = parent_of(pos);
  assign child_l      = left_of(pos);
  assign child_r      = child_l + CH_W'(1);
  assign right_ok     = child_r < CH_W'(fill_count);
  assign pick_right   = right_ok &&
                        (mem_rd_data_b[KEY_BITS-1:0] < mem_rd_data_a[KEY_BITS-1:0]);
  assign ch_ent       = pick_right ? mem_rd_data_b : mem_rd_data_a;
  assign ch_idx       = pick_right ? child_r[ADDR_W-1:0] : child_l[ADDR_W-1:0];
  assign gchild_l     = left_of(ch_idx);
  assign out_free     = !m_valid || m_ready;
  assign s_ready      = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    pos_next        = pos;
    key_q_next      = key_q;
    lab_q_next      = lab_q;
    res_label_next  = res_label;
    res_status_next = res_status;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = pos;
    mem_wr_data     = {lab_q, key_q};
    mem_rd_addr_a   = '0;
    mem_rd_addr_b   = '0;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          key_q_next = s_key;
          lab_q_next = s_label;
          if (s_mode == MODE_PUSH) begin
            if (fill_count >= eff_cap) begin
              res_label_next  = '0;
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              pos_next        = fill_idx;
              fill_count_next = fill_count + CNT_W'(1);
              res_label_next  = s_label;
              res_status_next = ST_OK;
              if (fill_count == '0) begin
                state_next = S_PLACE;
              end else begin
                mem_rd_addr_a = parent_of(fill_idx);
                state_next    = S_PUSH_CMP;
              end
            end
          end else begin
            if (fill_count == '0) begin
              res_label_next  = '0;
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              fill_count_next = fill_dec;
              pos_next        = '0;
              res_status_next = ST_OK;
              mem_rd_addr_a   = '0;
              mem_rd_addr_b   = fill_dec_idx;
              state_next      = S_POP_LOAD;
            end
          end
        end
      end
      S_PUSH_CMP: begin
        if (key_q < mem_rd_data_a[KEY_BITS-1:0]) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = mem_rd_data_a;
          pos_next    = up;
          if (up == '0) begin
            state_next = S_PLACE;
          end else begin
            mem_rd_addr_a = parent_of(up);
          end
        end else begin
          state_next = S_PLACE;
        end
      end
      S_POP_LOAD: begin
        res_label_next = mem_rd_data_a[ENT_W-1:KEY_BITS];
        key_q_next     = mem_rd_data_b[KEY_BITS-1:0];
        lab_q_next     = mem_rd_data_b[ENT_W-1:KEY_BITS];
        if (child_l >= CH_W'(fill_count)) begin
          state_next = S_PLACE;
        end else begin
          mem_rd_addr_a = child_l[ADDR_W-1:0];
          mem_rd_addr_b = child_r[ADDR_W-1:0];
          state_next    = S_POP_CMP;
        end
      end
      S_POP_CMP: begin
        if (key_q > ch_ent[KEY_BITS-1:0]) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = ch_ent;
          pos_next    = ch_idx;
          if (gchild_l >= CH_W'(fill_count)) begin
            state_next = S_PLACE;
          end else begin
            mem_rd_addr_a = gchild_l[ADDR_W-1:0];
            mem_rd_addr_b = ADDR_W'(gchild_l + CH_W'(1));
          end
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_wr_en  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    key_q      <= key_q_next;
    lab_q      <= lab_q_next;
    res_label  <= res_label_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_label     <= res_label;
      m_status    <= res_status;
      m_occupancy <= fill_count;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready) |=> (state != S_IDLE))
    else $error("accepted transaction left sequencer idle");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_status == ST_EMPTY) |-> (m_occupancy == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_status == ST_FULL) |-> (m_occupancy != '0 || capacity == '0))
    else $error("full status on empty heap with nonzero capacity");

endmodule

// File: src/binary_min_heap_queue_core.sv
// Binary min-heap priority queue: stream ports, capacity register, heap store.
// A push does parent compares and a place step, a pop a root load, child compares
// and a place step; a refused push or a pop on empty goes straight to the result.
// Output stalls hold it. A new transaction is taken only once the last result is in
// the output register; a heap level costs one store read and at most one store write.
// Reset clears occupancy and the output valid and sets capacity to DEPTH;
// the entry store is not cleared and needs no clearing pass.
module binary_min_heap_queue_core #(
  parameter int DEPTH    = bhq_pkg::DEF_DEPTH,
  parameter int KEY_BITS = bhq_pkg::DEF_KEY_BITS,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int S_W     = ((KEY_BITS + bhq_pkg::LABEL_BITS + 7) / 8) * 8,
  localparam int M_W     = ((bhq_pkg::LABEL_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [S_W-1:0]                  s_tdata,   // key, block_label
  input  logic                            s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [M_W-1:0]                  m_tdata,   // label_out, occupancy
  output logic [bhq_pkg::STATUS_BITS-1:0] m_tuser,   // status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CNT_W-1:0]                cfg_data
);
  import bhq_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W  = KEY_BITS + LABEL_BITS;

  logic [CNT_W-1:0]      capacity;
  logic [LABEL_BITS-1:0] out_label;
  logic [CNT_W-1:0]      out_occ;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [ENT_W-1:0]      wr_data, rd_data_a, rd_data_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(DEPTH);
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    m_tdata                       = '0;
    m_tdata[LABEL_BITS-1:0]       = out_label;
    m_tdata[LABEL_BITS +: CNT_W]  = out_occ;
  end

  bhq_ctrl #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .CNT_W    (CNT_W),
    .ADDR_W   (ADDR_W),
    .ENT_W    (ENT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_valid       (s_tvalid),
    .s_ready       (s_tready),
    .s_mode        (s_tuser),
    .s_key         (s_tdata[KEY_BITS-1:0]),
    .s_label       (s_tdata[KEY_BITS +: LABEL_BITS]),
    .capacity      (capacity),
    .m_valid       (m_tvalid),
    .m_ready       (m_tready),
    .m_label       (out_label),
    .m_status      (m_tuser),
    .m_occupancy   (out_occ),
    .mem_wr_en     (wr_en),
    .mem_wr_addr   (wr_addr),
    .mem_wr_data   (wr_data),
    .mem_rd_addr_a (rd_addr_a),
    .mem_rd_addr_b (rd_addr_b),
    .mem_rd_data_a (rd_data_a),
    .mem_rd_data_b (rd_data_b)
  );

  bhq_mem #(
    .DEPTH  (DEPTH),
    .ENT_W  (ENT_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

// File: sim/binary_min_heap_queue_core_test.sv
// Self-checking testbench for the binary min-heap priority queue core.
module binary_min_heap_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhq_pkg::*;

  localparam int DEPTH   = DEF_DEPTH;
  localparam int KW      = DEF_KEY_BITS;
  localparam int LW      = LABEL_BITS;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int SW      = ((KW + LW + 7) / 8) * 8;
  localparam int MW      = ((LW + CW + 7) / 8) * 8;
  localparam int NROWS   = 25;
  localparam int NPHASES = 12;
  localparam int PHASE_N = 75;
  localparam int LIMIT   = 400000;

  typedef struct packed {
    logic [LW-1:0]          label;
    logic [STATUS_BITS-1:0] status;
    logic [CW-1:0]          occ;
  } heap_result_t;

  typedef struct packed {
    bit           set_cap;
    logic [CW-1:0] cap;
    logic         mode;
    logic [KW-1:0] key;
    logic [LW-1:0] lab;
    bit           typed;
    heap_result_t want;
  } op_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SW-1:0]          s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [MW-1:0]          m_tdata;
  logic [STATUS_BITS-1:0] m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CW-1:0]          cfg_data = '0;

  binary_min_heap_queue_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // own copy of the heap
  logic [KW-1:0]  pq_key [DEPTH];
  logic [LW-1:0]  pq_lab [DEPTH];
  int unsigned    pq_fill;
  int unsigned    pq_cap;
  heap_result_t   due_responses[$];
  int             errors = 0;
  int             cycles = 0;
  bit             src_idle_en = 1'b1;
  bit             sink_idle_en = 1'b1;
  int             stall_left = 0;
  bit             row_typed = 1'b0;
  heap_result_t   row_want = '0;
  op_row_t        op_rows [NROWS];

  function automatic heap_result_t heap_op(logic mode, logic [KW-1:0] k, logic [LW-1:0] lab);
    heap_result_t  r;
    int unsigned   lim;
    int unsigned   pos;
    int unsigned   up;
    int unsigned   c;
    logic [KW-1:0] mk;
    logic [LW-1:0] ml;
    bit            done;
    r = '0;
    lim = (pq_cap > DEPTH) ? DEPTH : pq_cap;
    if (mode == MODE_PUSH) begin
      if (pq_fill >= lim) begin
        r.status = ST_FULL;
      end else begin
        pos = pq_fill;
        pq_fill++;
        done = 1'b0;
        while (pos > 0 && !done) begin
          up = (pos - 1) >> 1;
          if (k < pq_key[up]) begin
            pq_key[pos] = pq_key[up];
            pq_lab[pos] = pq_lab[up];
            pos = up;
          end else begin
            done = 1'b1;
          end
        end
        pq_key[pos] = k;
        pq_lab[pos] = lab;
        r.label = lab;
        r.status = ST_OK;
      end
    end else if (pq_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.label = pq_lab[0];
      r.status = ST_OK;
      pq_fill--;
      mk = pq_key[pq_fill];
      ml = pq_lab[pq_fill];
      pos = 0;
      done = 1'b0;
      while (!done) begin
        c = (pos << 1) + 1;
        if (c >= pq_fill) begin
          done = 1'b1;
        end else begin
          if (c + 1 < pq_fill && pq_key[c + 1] < pq_key[c]) c = c + 1;
          if (mk > pq_key[c]) begin
            pq_key[pos] = pq_key[c];
            pq_lab[pos] = pq_lab[c];
            pos = c;
          end else begin
            done = 1'b1;
          end
        end
      end
      pq_key[pos] = mk;
      pq_lab[pos] = ml;
    end
    r.occ = pq_fill[CW-1:0];
    return r;
  endfunction

  function automatic op_row_t mk_row(bit set_cap, int cap, logic mode, logic [KW-1:0] key,
                                     logic [LW-1:0] lab, bit typed, logic [LW-1:0] wl,
                                     logic [STATUS_BITS-1:0] ws, int wo);
    op_row_t r;
    r.set_cap = set_cap;
    r.cap = cap[CW-1:0];
    r.mode = mode;
    r.key = key;
    r.lab = lab;
    r.typed = typed;
    r.want.label = wl;
    r.want.status = ws;
    r.want.occ = wo[CW-1:0];
    return r;
  endfunction

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 13) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // predict on every accepted transaction, check every delivered result
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    heap_result_t pred;
    if (rst) begin
      pq_fill = 0;
      pq_cap = DEPTH;
    end else begin
      if (m_tvalid && m_tready) begin
        got.label = m_tdata[LW-1:0];
        got.occ = m_tdata[LW +: CW];
        got.status = m_tuser;
        if (due_responses.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: label %02h status %0d occupancy %0d",
                     got.label, got.status, got.occ);
          errors++;
        end else begin
          want = due_responses.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("expected label %02h status %0d occupancy %0d, got %02h %0d %0d",
                       want.label, want.status, want.occ, got.label, got.status, got.occ);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) pq_cap = cfg_data;
      if (s_tvalid && s_tready) begin
        pred = heap_op(s_tuser, s_tdata[KW-1:0], s_tdata[KW +: LW]);
        due_responses.push_back(row_typed ? row_want : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("binary_min_heap_queue_core: mismatch");
      $finish;
    end
  end

  task automatic send_op(input logic mode, input logic [KW-1:0] key, input logic [LW-1:0] lab,
                         input bit typed, input heap_result_t want);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= SW'({$urandom, $urandom, $urandom});
      s_tuser <= 1'($urandom);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= SW'({lab, key});
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic await_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [KW-1:0] rk;
    logic          rm;
    int            sel;
    int            bias;
    int            cap;
    op_row_t       row;

    op_rows[0]  = mk_row(0, 0, MODE_POP, '0, 8'h00, 1, 8'h00, ST_EMPTY, 0);
    op_rows[1]  = mk_row(0, 0, MODE_PUSH, {KW{1'b1}}, 8'hFF, 1, 8'hFF, ST_OK, 1);
    op_rows[2]  = mk_row(0, 0, MODE_PUSH, '0, 8'h00, 1, 8'h00, ST_OK, 2);
    op_rows[3]  = mk_row(0, 0, MODE_PUSH, KW'(5), 8'h11, 0, 8'h00, ST_OK, 0);
    op_rows[4]  = mk_row(0, 0, MODE_PUSH, KW'(5), 8'h22, 0, 8'h00, ST_OK, 0);
    op_rows[5]  = mk_row(0, 0, MODE_POP, KW'(9), 8'h99, 1, 8'h00, ST_OK, 3);
    op_rows[6]  = mk_row(0, 0, MODE_POP, '0, 8'h00, 0, 8'h00, ST_OK, 0);
    op_rows[7]  = mk_row(0, 0, MODE_POP, '0, 8'h00, 0, 8'h00, ST_OK, 0);
    op_rows[8]  = mk_row(0, 0, MODE_POP, '0, 8'h00, 1, 8'hFF, ST_OK, 0);
    op_rows[9]  = mk_row(0, 0, MODE_POP, {KW{1'b1}}, 8'hFF, 1, 8'h00, ST_EMPTY, 0);
    op_rows[10] = mk_row(1, 1, MODE_PUSH, KW'(7), 8'h5A, 1, 8'h5A, ST_OK, 1);
    op_rows[11] = mk_row(0, 0, MODE_PUSH, KW'(3), 8'hA5, 1, 8'h00, ST_FULL, 1);
    op_rows[12] = mk_row(0, 0, MODE_POP, '0, 8'h00, 1, 8'h5A, ST_OK, 0);
    op_rows[13] = mk_row(1, 0, MODE_PUSH, KW'(1), 8'h01, 1, 8'h00, ST_FULL, 0);
    op_rows[14] = mk_row(0, 0, MODE_POP, '0, 8'h00, 1, 8'h00, ST_EMPTY, 0);
    op_rows[15] = mk_row(1, 31, MODE_PUSH, KW'(64'h2AAA_AAAA_AAAA_AAAA), 8'h80, 0,
                         8'h00, ST_OK, 0);
    op_rows[16] = mk_row(0, 0, MODE_PUSH, KW'(64'h5555_5555_5555_5555), 8'h7F, 0,
                         8'h00, ST_OK, 0);
    op_rows[17] = mk_row(0, 0, MODE_PUSH, {KW{1'b1}}, 8'h01, 0, 8'h00, ST_OK, 0);
    op_rows[18] = mk_row(1, 2, MODE_PUSH, KW'(9), 8'h33, 1, 8'h00, ST_FULL, 3);
    op_rows[19] = mk_row(0, 0, MODE_POP, '0, 8'h00, 0, 8'h00, ST_OK, 0);
    op_rows[20] = mk_row(0, 0, MODE_PUSH, KW'(2), 8'h66, 1, 8'h00, ST_FULL, 2);
    op_rows[21] = mk_row(0, 0, MODE_POP, '0, 8'h00, 0, 8'h00, ST_OK, 0);
    op_rows[22] = mk_row(0, 0, MODE_PUSH, KW'(4), 8'h44, 0, 8'h00, ST_OK, 0);
    op_rows[23] = mk_row(1, 16, MODE_POP, '0, 8'h00, 0, 8'h00, ST_OK, 0);
    op_rows[24] = mk_row(0, 0, MODE_POP, '0, 8'h00, 0, 8'h00, ST_OK, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      row = op_rows[i];
      if (row.set_cap) begin
        await_quiet();
        write_capacity(row.cap);
      end
      send_op(row.mode, row.key, row.lab, row.typed, row.want);
    end

    for (int p = 0; p < NPHASES; p++) begin
      await_quiet();
      case (p)
        0, 11:   cap = DEPTH;
        1:       cap = 31;
        2:       cap = 1;
        3:       cap = 0;
        default: cap = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                   : $urandom_range(1, 16);
      endcase
      write_capacity(cap[CW-1:0]);
      src_idle_en = (p < NPHASES - 2) && (p % 3 != 2);
      sink_idle_en = (p < NPHASES - 2) && (p % 4 != 3);
      for (int i = 0; i < PHASE_N; i++) begin
        case (p % 3)
          0:       bias = (i < 45) ? 85 : 20;
          1:       bias = (i < 30) ? 70 : 35;
          default: bias = 50;
        endcase
        rm = ($urandom_range(0, 99) < bias) ? MODE_PUSH : MODE_POP;
        sel = $urandom_range(0, 9);
        if (sel < 3) rk = KW'($urandom_range(0, 7));
        else if (sel == 3) rk = {KW{1'b1}} - KW'($urandom_range(0, 3));
        else if (sel == 4) rk = '0;
        else rk = KW'({$urandom, $urandom});
        send_op(rm, rk, LW'($urandom), 1'b0, '0);
      end
    end

    await_quiet();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("binary_min_heap_queue_core: match");
    end else begin
      $display("binary_min_heap_queue_core: mismatch");
    end
    $finish;
  end

endmodule

// File: binary_min_heap_queue_core.f
src/bhq_pkg.sv
src/bhq_mem.sv
src/bhq_ctrl.sv
src/binary_min_heap_queue_core.sv
sim/binary_min_heap_queue_core_test.sv
